FILE: hdl/packet_and_message_deframer_macros.svh
// assertion macros for the packet and message deframer
// used by packet_and_message_deframer.sv, no other dependencies
`ifndef PACKET_AND_MESSAGE_DEFRAMER_MACROS_SVH
`define PACKET_AND_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PMD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, disabled while in reset
`define PMD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: hdl/pmd_pkg.sv
// types and constants shared by the deframer modules
// no dependencies
`default_nettype none

package pmd_pkg;

  // parser position inside a packet
  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_LEN     = 4'd1,
    PH_RAW     = 4'd2,
    PH_COMP    = 4'd3,
    PH_FLAGS   = 4'd4,
    PH_FLEN    = 4'd5,
    PH_DATA    = 4'd6,
    PH_CONTENT = 4'd7,
    PH_DISCARD = 4'd8
  } phase_t;

  // role tag given to each word
  typedef enum logic [3:0] {
    ROLE_HEADER  = 4'd0,
    ROLE_LEN     = 4'd1,
    ROLE_RAW     = 4'd2,
    ROLE_COMP    = 4'd3,
    ROLE_FLAGS   = 4'd4,
    ROLE_FLEN    = 4'd5,
    ROLE_FDATA   = 4'd6,
    ROLE_TIME    = 4'd7,
    ROLE_CONTENT = 4'd8,
    ROLE_DISCARD = 4'd9
  } role_t;

  localparam logic [2:0] FID_TIME  = 3'd4;
  localparam logic [2:0] FID_EXTRA = 3'd5;
  localparam int unsigned NUM_FIELDS = 6;
  localparam logic [2:0] LEN_LAST_BYTE = 3'd2;
  localparam logic [23:0] TIME_BYTES = 24'd8;
  localparam logic [23:0] EXTRA_LEN_BYTES = 24'd2;

  // outcome of a search for the next present field
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  fidx;
    logic [15:0] frem;
    logic [1:0]  lbc;
    logic        err;
  } nf_t;

  // one tagged word
  typedef struct packed {
    logic [7:0]  data;
    logic [3:0]  kind;
    role_t       role;
    logic [2:0]  fid;
    logic [23:0] bsize;
    logic        done;
    logic        err;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/pmd_core.sv
// parse state and per-word tagging logic of the deframer
// depends on pmd_pkg
`default_nettype none

module pmd_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic [7:0]    rx_byte,
  input  wire logic [3:0]    message_type,
  output pmd_pkg::res_t      res
);

  pmd_pkg::phase_t ph_r, ph_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic        comp_r, comp_nxt;
  logic [23:0] la_r, la_nxt;
  logic [23:0] br_r, br_nxt;
  logic [5:0]  pf_r, pf_nxt;
  logic [2:0]  fi_r, fi_nxt;
  logic [15:0] fr_r, fr_nxt;
  logic [1:0]  lbc_r, lbc_nxt;
  logic        err_r, err_nxt;

  // first present field at or after index from, with room check
  function automatic pmd_pkg::nf_t next_field(
    input logic [5:0]  flags,
    input logic [2:0]  from,
    input logic [23:0] br,
    input logic [2:0]  fi_cur,
    input logic [15:0] fr_cur,
    input logic [1:0]  lbc_cur
  );
    pmd_pkg::nf_t r;
    logic [5:0]   avail;
    logic [2:0]   idx;
    r.phase = pmd_pkg::PH_CONTENT;
    r.fidx  = fi_cur;
    r.frem  = fr_cur;
    r.lbc   = lbc_cur;
    r.err   = 1'b0;
    idx     = 3'd0;
    for (int i = 0; i < pmd_pkg::NUM_FIELDS; i++) begin
      avail[i] = flags[i] && (3'(i) >= from);
    end
    for (int i = pmd_pkg::NUM_FIELDS - 1; i >= 0; i--) begin
      if (avail[i]) idx = 3'(i);
    end
    if (|avail) begin
      r.fidx = idx;
      r.lbc  = 2'd0;
      if (idx == pmd_pkg::FID_TIME) begin
        if (br < pmd_pkg::TIME_BYTES) begin
          r.phase = pmd_pkg::PH_DISCARD;
          r.err   = 1'b1;
        end else begin
          r.frem  = 16'(pmd_pkg::TIME_BYTES);
          r.phase = pmd_pkg::PH_DATA;
        end
      end else if (idx == pmd_pkg::FID_EXTRA) begin
        if (br < pmd_pkg::EXTRA_LEN_BYTES) begin
          r.phase = pmd_pkg::PH_DISCARD;
          r.err   = 1'b1;
        end else begin
          r.phase = pmd_pkg::PH_FLEN;
        end
      end else begin
        if (br == 24'd0) begin
          r.phase = pmd_pkg::PH_DISCARD;
          r.err   = 1'b1;
        end else begin
          r.phase = pmd_pkg::PH_FLEN;
        end
      end
    end
    return r;
  endfunction

  pmd_pkg::nf_t nf;
  pmd_pkg::role_t role;
  logic [2:0]  fid;
  logic [23:0] bsize;
  logic        done;
  logic [23:0] la_k;
  logic [23:0] br_dec;
  logic [15:0] fr_k;
  logic [15:0] fr_dec;
  logic [1:0]  lbc_k;
  logic        have_len;

  always_comb begin
    ph_nxt   = ph_r;
    kind_nxt = kind_r;
    comp_nxt = comp_r;
    la_nxt   = la_r;
    br_nxt   = br_r;
    pf_nxt   = pf_r;
    fi_nxt   = fi_r;
    fr_nxt   = fr_r;
    lbc_nxt  = lbc_r;
    err_nxt  = err_r;
    role     = pmd_pkg::ROLE_HEADER;
    fid      = 3'd0;
    bsize    = 24'd0;
    done     = 1'b0;
    nf       = '0;
    la_k     = {la_r[15:0], rx_byte};
    br_dec   = (br_r != 24'd0) ? br_r - 24'd1 : br_r;
    fr_dec   = (fr_r != 16'd0) ? fr_r - 16'd1 : fr_r;
    fr_k     = {8'h00, rx_byte};
    lbc_k    = lbc_r;
    have_len = 1'b0;

    unique case (ph_r) inside
      pmd_pkg::PH_LEN: begin
        role   = pmd_pkg::ROLE_LEN;
        la_nxt = la_k;
        if ({1'b0, lbc_r} == pmd_pkg::LEN_LAST_BYTE) begin
          lbc_nxt = 2'd0;
          bsize   = la_k;
          if (la_k == 24'd0) begin
            done   = 1'b1;
            ph_nxt = pmd_pkg::PH_HEADER;
          end else begin
            br_nxt = la_k;
            if (comp_r) ph_nxt = pmd_pkg::PH_COMP;
            else if (kind_r == message_type) ph_nxt = pmd_pkg::PH_FLAGS;
            else ph_nxt = pmd_pkg::PH_RAW;
          end
        end else begin
          lbc_nxt = lbc_r + 2'd1;
        end
      end
      pmd_pkg::PH_RAW, pmd_pkg::PH_COMP, pmd_pkg::PH_FLAGS, pmd_pkg::PH_FLEN,
      pmd_pkg::PH_DATA, pmd_pkg::PH_CONTENT, pmd_pkg::PH_DISCARD: begin
        bsize  = la_r;
        br_nxt = br_dec;
        case (ph_r)
          pmd_pkg::PH_RAW:  role = pmd_pkg::ROLE_RAW;
          pmd_pkg::PH_COMP: role = pmd_pkg::ROLE_COMP;
          pmd_pkg::PH_FLAGS: begin
            role    = pmd_pkg::ROLE_FLAGS;
            pf_nxt  = rx_byte[5:0];
            nf      = next_field(rx_byte[5:0], 3'd0, br_dec, fi_r, fr_r, lbc_r);
            ph_nxt  = nf.phase;
            fi_nxt  = nf.fidx;
            fr_nxt  = nf.frem;
            lbc_nxt = nf.lbc;
            err_nxt = err_r | nf.err;
          end
          pmd_pkg::PH_FLEN: begin
            role = pmd_pkg::ROLE_FLEN;
            fid  = fi_r;
            if (fi_r == pmd_pkg::FID_EXTRA) begin
              if (lbc_r == 2'd0) begin
                fr_nxt  = {rx_byte, 8'h00};
                lbc_nxt = 2'd1;
              end else begin
                fr_k     = fr_r | {8'h00, rx_byte};
                lbc_k    = 2'd0;
                have_len = 1'b1;
              end
            end else begin
              have_len = 1'b1;
            end
            // field length complete
            if (have_len) begin
              fr_nxt  = fr_k;
              lbc_nxt = lbc_k;
              if (fr_k == 16'd0) begin
                nf      = next_field(pf_r, 3'(fi_r + 3'd1), br_dec, fi_r, fr_k, lbc_k);
                ph_nxt  = nf.phase;
                fi_nxt  = nf.fidx;
                fr_nxt  = nf.frem;
                lbc_nxt = nf.lbc;
                err_nxt = err_r | nf.err;
              end else if ({8'h00, fr_k} > br_dec) begin
                ph_nxt  = pmd_pkg::PH_DISCARD;
                err_nxt = 1'b1;
              end else begin
                ph_nxt = pmd_pkg::PH_DATA;
              end
            end
          end
          pmd_pkg::PH_DATA: begin
            role   = (fi_r == pmd_pkg::FID_TIME) ? pmd_pkg::ROLE_TIME : pmd_pkg::ROLE_FDATA;
            fid    = fi_r;
            fr_nxt = fr_dec;
            if (fr_dec == 16'd0) begin
              nf      = next_field(pf_r, 3'(fi_r + 3'd1), br_dec, fi_r, fr_dec, lbc_r);
              ph_nxt  = nf.phase;
              fi_nxt  = nf.fidx;
              fr_nxt  = nf.frem;
              lbc_nxt = nf.lbc;
              err_nxt = err_r | nf.err;
            end
          end
          pmd_pkg::PH_CONTENT: role = pmd_pkg::ROLE_CONTENT;
          default:             role = pmd_pkg::ROLE_DISCARD;
        endcase
        // last body word closes the packet
        if (br_dec == 24'd0) begin
          done   = 1'b1;
          ph_nxt = pmd_pkg::PH_HEADER;
        end
      end
      default: begin
        kind_nxt = rx_byte[3:0];
        comp_nxt = rx_byte[6];
        la_nxt   = 24'd0;
        br_nxt   = 24'd0;
        pf_nxt   = 6'd0;
        fi_nxt   = 3'd0;
        fr_nxt   = 16'd0;
        lbc_nxt  = 2'd0;
        err_nxt  = 1'b0;
        role     = pmd_pkg::ROLE_HEADER;
        if (rx_byte[7]) begin
          ph_nxt = pmd_pkg::PH_LEN;
        end else begin
          ph_nxt = pmd_pkg::PH_HEADER;
          done   = 1'b1;
        end
      end
    endcase

    res.data  = rx_byte;
    res.kind  = kind_nxt;
    res.role  = role;
    res.fid   = fid;
    res.bsize = bsize;
    res.done  = done;
    res.err   = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= pmd_pkg::PH_HEADER;
      kind_r <= 4'd0;
      comp_r <= 1'b0;
      la_r   <= 24'd0;
      br_r   <= 24'd0;
      pf_r   <= 6'd0;
      fi_r   <= 3'd0;
      fr_r   <= 16'd0;
      lbc_r  <= 2'd0;
      err_r  <= 1'b0;
    end else if (step) begin
      ph_r   <= ph_nxt;
      kind_r <= kind_nxt;
      comp_r <= comp_nxt;
      la_r   <= la_nxt;
      br_r   <= br_nxt;
      pf_r   <= pf_nxt;
      fi_r   <= fi_nxt;
      fr_r   <= fr_nxt;
      lbc_r  <= lbc_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/packet_and_message_deframer.sv
// top level of the packet and message deframer: handshake, config register, result register
// depends on pmd_pkg, pmd_core and packet_and_message_deframer_macros.svh
// ---------------------------------------------------------------------------------------------
// Tags each received byte with its role in the packet stream: header, body length, raw or
// compressed body, or, for uncompressed packets whose type equals the message_type register,
// message flags, field lengths, field data, time, content, or discarded after a format error.
// Every word in gives exactly one word out. Throughput is one word per clock while out_stall is low;
// out_valid rises once the word has passed the input register, which takes it at the accepting
// edge on the in_ channel, and the result register, fed by the tagging logic in pmd_core. The in_
// side keeps accepting while a result waits, as long as the input register is free or moving
// on. cfg_wdata is written when cfg_we is high and must only change while no word is in flight.
`default_nettype none
`include "packet_and_message_deframer_macros.svh"

module packet_and_message_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  // input words
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_rx_byte,
  // tagged words
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [3:0]       out_packet_kind,
  output logic [3:0]       out_byte_role,
  output logic [2:0]       out_field_id,
  output logic [23:0]      out_body_size,
  output logic             out_packet_done,
  output logic             out_format_error
);

  logic [3:0]    msg_type_r;
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          out_valid_r;
  pmd_pkg::res_t out_r;
  pmd_pkg::res_t res;
  logic          adv;
  logic          in_acc;
  logic          out_is_hdr;
  logic          out_in_msg;

  // result register free or being drained this cycle
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // message type register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_type_r <= 4'd0;
    end else if (cfg_we) begin
      msg_type_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // parse state advances only when the word moves into the result register
  pmd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv && s1_valid_r),
    .rx_byte      (s1_byte_r),
    .message_type (msg_type_r),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_r.data;
  assign out_packet_kind  = out_r.kind;
  assign out_byte_role    = 4'(out_r.role);
  assign out_field_id     = out_r.fid;
  assign out_body_size    = out_r.bsize;
  assign out_packet_done  = out_r.done;
  assign out_format_error = out_r.err;

  // roles seen by the assertions
  assign out_is_hdr = out_valid_r && (out_r.role == pmd_pkg::ROLE_HEADER);
  assign out_in_msg = (out_r.role == pmd_pkg::ROLE_FLAGS) ||
                      (out_r.role == pmd_pkg::ROLE_FLEN) ||
                      (out_r.role == pmd_pkg::ROLE_FDATA) ||
                      (out_r.role == pmd_pkg::ROLE_TIME) ||
                      (out_r.role == pmd_pkg::ROLE_DISCARD);

  // a word leaving the input register always lands in the result register
  `PMD_ASSERT_NXT(a_adv_fills_out, clk, rst_n, s1_valid_r && adv, out_valid_r)

  // back-pressure on the input only when the input register is occupied
  `PMD_ASSERT_IMP(a_stall_needs_s1, clk, rst_n, in_stall, s1_valid_r)

  // header words never carry a body size
  `PMD_ASSERT_IMP(a_hdr_no_size, clk, rst_n, out_is_hdr, out_r.bsize == 24'd0)

  // errors only show up inside a parsed message body
  `PMD_ASSERT_IMP(a_err_in_msg, clk, rst_n, out_valid_r && out_r.err, out_in_msg)

endmodule

`default_nettype wire
